// ===== rtl/core/tbvs_pkg.sv =====
// ----------------------------------------------------------------------------
// tbvs_pkg: shared types and constants for the two-bone skinning engine
// Transfer payload structs, function codes, arithmetic widths, saturation
// limits and the bone-number helper used by the core.
// ----------------------------------------------------------------------------
package tbvs_pkg;

   // Store geometry
   localparam int MAX_BONES      = 64;
   localparam int WORDS_PER_BONE = 12;
   localparam int ELEM_BITS      = 32;
   localparam int BONE_BITS      = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
   localparam int ROW_BITS       = WORDS_PER_BONE * ELEM_BITS;
   localparam int TRANS_ROW      = 3;

   // Arithmetic widths
   localparam int VALUE_BITS   = 32;
   localparam int VALUE_FRAC   = 16;
   localparam int WEIGHT_BITS  = 16;
   localparam int WEIGHT_FRAC  = 15;
   localparam int PROD_BITS    = 2 * ELEM_BITS;
   localparam int ACC_BITS     = PROD_BITS + 2;
   localparam int SUM_BITS     = ACC_BITS - VALUE_FRAC;
   localparam int TRAN_BITS    = SUM_BITS + 1;
   localparam int WPROD_BITS   = VALUE_BITS + WEIGHT_BITS + 1;
   localparam int ACC2_BITS    = WPROD_BITS + 2;
   localparam int MIX_BITS     = ACC2_BITS - WEIGHT_FRAC;
   localparam int OUT_BITS     = 32;
   localparam int RAW_BITS     = 8;
   localparam int BNUM_BITS    = 7;

   typedef logic signed [ELEM_BITS-1:0]  elem_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [ACC_BITS-1:0]   acc_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;
   typedef logic signed [TRAN_BITS-1:0]  tran_type;
   typedef logic signed [VALUE_BITS-1:0] comp_type;
   typedef logic signed [WPROD_BITS-1:0] wprod_type;
   typedef logic signed [ACC2_BITS-1:0]  acc2_type;
   typedef logic signed [MIX_BITS-1:0]   blend_type;
   typedef logic signed [OUT_BITS-1:0]   out_type;
   typedef logic [ROW_BITS-1:0]          row_type;
   typedef logic [WORDS_PER_BONE-1:0]    lane_type;

   // Round half up constants and saturation limits
   localparam acc_type  ACC_ROUND  = acc_type'(longint'(1) <<< (VALUE_FRAC - 1));
   localparam acc2_type ACC2_ROUND = acc2_type'(longint'(1) <<< (WEIGHT_FRAC - 1));
   localparam longint   COMP_MAX   = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
   localparam longint   COMP_MIN   = -COMP_MAX - 1;
   localparam longint   OUT_MAX    = (longint'(1) <<< (OUT_BITS - 1)) - 1;
   localparam longint   OUT_MIN    = -OUT_MAX - 1;
   localparam lane_type LANE_ONE   = {{(WORDS_PER_BONE-1){1'b0}}, 1'b1};

   // Function codes
   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_POINT = 2'd1,
      FUNC_DIR   = 2'd2
   } func_type;

   typedef struct packed {
      logic [1:0]              func;
      logic [5:0]              load_bone;
      logic [3:0]              elem_index;
      logic signed [31:0]      elem_value;
      logic [7:0]              bone_first;
      logic [7:0]              bone_second;
      logic [15:0]             weight_first;
      logic [15:0]             weight_second;
      logic signed [31:0]      vec_x;
      logic signed [31:0]      vec_y;
      logic signed [31:0]      vec_z;
      logic                    last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [31:0]      out_x;
      logic signed [31:0]      out_y;
      logic signed [31:0]      out_z;
      logic                    out_last;
   } rsp_type;

   // Raw bone index divided by 3: multiply by 171/512, exact for 8-bit input
   function automatic logic [BNUM_BITS-1:0] bone_of_raw(input logic [RAW_BITS-1:0] raw);
      logic [15:0] scaled;
      scaled = {8'd0, raw} * 16'd171;
      return scaled[15:9];
   endfunction

endpackage

// ===== rtl/core/two_bone_vertex_skinning.sv =====
// ----------------------------------------------------------------------------
// two_bone_vertex_skinning: two-bone linear blend skinning engine
// Stores 4x3 bone matrices and blends each vertex vector through two bones.
// ----------------------------------------------------------------------------
// The engine takes one item per clock: load items and transform items may
// follow each other with no gap, with a full stall passing back to req_ready
// only when every pipeline stage is occupied. A transform passes through the
// matrix RAM, which holds one 12-word row per bone and serves both bones of a
// vertex through its two read ports in the same cycle, and through the
// five-stage arithmetic pipeline behind it (matrix products, rounding sum,
// translation and saturation, weighting, blend). Loads write the RAM at their
// transfer, so a transform right after a load already sees the new word. The
// matrix store is not cleared at reset; a word must be loaded before a
// transform uses it. Bone numbers beyond the store contribute zero, and loads
// outside it are dropped.
// ----------------------------------------------------------------------------
module two_bone_vertex_skinning (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tbvs_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tbvs_pkg::rsp_type rsp_payload
);

   // Handshake and stage control
   logic       req_accept;
   logic       is_xform;
   logic [6:1] valid_ff;
   logic [6:1] valid_in;
   logic [6:1] adv;

   // Matrix RAM ports
   logic                             wr_en;
   logic [tbvs_pkg::BONE_BITS-1:0]   wr_addr;
   tbvs_pkg::lane_type               wr_lane_en;
   tbvs_pkg::row_type                wr_data;
   logic                             rd_en;
   logic [tbvs_pkg::BNUM_BITS-1:0]   bnum [2];
   tbvs_pkg::row_type                rd_row [2];

   // Stage 1: RAM data plus vertex payload
   logic                             point_s1_ff;
   logic                             last_s1_ff;
   logic                             oob_s1_ff [2];
   tbvs_pkg::elem_type               vec_s1_ff [3];
   logic [tbvs_pkg::WEIGHT_BITS-1:0] wt_s1_ff [2];

   // Stage 2: matrix products
   tbvs_pkg::prod_type               prod_s2_in [2][3][3];
   tbvs_pkg::prod_type               prod_s2_ff [2][3][3];
   tbvs_pkg::elem_type               trans_s2_in [2][3];
   tbvs_pkg::elem_type               trans_s2_ff [2][3];
   logic                             oob_s2_ff [2];
   logic [tbvs_pkg::WEIGHT_BITS-1:0] wt_s2_ff [2];
   logic                             last_s2_ff;

   // Stage 3: rounded rotation sums
   tbvs_pkg::acc_type                acc_s3 [2][3];
   tbvs_pkg::sum_type                sum_s3_in [2][3];
   tbvs_pkg::sum_type                sum_s3_ff [2][3];
   tbvs_pkg::elem_type               trans_s3_ff [2][3];
   logic                             oob_s3_ff [2];
   logic [tbvs_pkg::WEIGHT_BITS-1:0] wt_s3_ff [2];
   logic                             last_s3_ff;

   // Stage 4: saturated bone components
   tbvs_pkg::tran_type               tsum_s4 [2][3];
   tbvs_pkg::comp_type               comp_s4_in [2][3];
   tbvs_pkg::comp_type               comp_s4_ff [2][3];
   logic [tbvs_pkg::WEIGHT_BITS-1:0] wt_s4_ff [2];
   logic                             last_s4_ff;

   // Stage 5: weighted components
   tbvs_pkg::wprod_type              wprod_s5_in [2][3];
   tbvs_pkg::wprod_type              wprod_s5_ff [2][3];
   logic                             last_s5_ff;

   // Stage 6: blended output register
   tbvs_pkg::acc2_type               acc2_s6 [3];
   tbvs_pkg::blend_type              blend_s6 [3];
   tbvs_pkg::out_type                out_s6 [3];
   tbvs_pkg::rsp_type                rsp_in;
   tbvs_pkg::rsp_type                rsp_ff;

   // Advance chain: a stage moves when empty or when the next one moves
   always_comb begin
      adv[6] = !valid_ff[6] || rsp_ready;
      for (int k = 5; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_ready  = adv[1];
   assign req_accept = req_valid && req_ready;
   assign is_xform   = (req_payload.func == tbvs_pkg::FUNC_POINT) ||
                       (req_payload.func == tbvs_pkg::FUNC_DIR);

   // Stage valid next values
   always_comb begin
      valid_in = valid_ff;
      if (adv[1]) begin
         valid_in[1] = req_accept && is_xform;
      end
      for (int k = 2; k <= 6; k++) begin
         if (adv[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load path: write one word of a bone row
   assign wr_en = req_accept && (req_payload.func == tbvs_pkg::FUNC_LOAD) &&
                  (req_payload.load_bone < tbvs_pkg::MAX_BONES) &&
                  (req_payload.elem_index < tbvs_pkg::WORDS_PER_BONE);
   assign wr_addr    = tbvs_pkg::BONE_BITS'(req_payload.load_bone);
   assign wr_lane_en = tbvs_pkg::LANE_ONE << req_payload.elem_index;
   assign wr_data    = {tbvs_pkg::WORDS_PER_BONE{req_payload.elem_value}};

   // Transform path: read both bone rows at the transfer
   assign rd_en   = req_accept && is_xform;
   assign bnum[0] = tbvs_pkg::bone_of_raw(req_payload.bone_first);
   assign bnum[1] = tbvs_pkg::bone_of_raw(req_payload.bone_second);

   tbvs_ram #(
      .LANE_BITS (tbvs_pkg::ELEM_BITS),
      .LANES     (tbvs_pkg::WORDS_PER_BONE),
      .DEPTH     (tbvs_pkg::MAX_BONES)
   ) u_matrix_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_lane_en (wr_lane_en),
      .wr_data    (wr_data),
      .rd_a_en    (rd_en),
      .rd_a_addr  (tbvs_pkg::BONE_BITS'(bnum[0])),
      .rd_a_data  (rd_row[0]),
      .rd_b_en    (rd_en),
      .rd_b_addr  (tbvs_pkg::BONE_BITS'(bnum[1])),
      .rd_b_data  (rd_row[1])
   );

   // Stage 1 payload alongside the RAM read
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         point_s1_ff  <= (req_payload.func == tbvs_pkg::FUNC_POINT);
         last_s1_ff   <= req_payload.last_vertex;
         oob_s1_ff[0] <= (bnum[0] >= tbvs_pkg::MAX_BONES);
         oob_s1_ff[1] <= (bnum[1] >= tbvs_pkg::MAX_BONES);
         vec_s1_ff[0] <= req_payload.vec_x;
         vec_s1_ff[1] <= req_payload.vec_y;
         vec_s1_ff[2] <= req_payload.vec_z;
         wt_s1_ff[0]  <= req_payload.weight_first;
         wt_s1_ff[1]  <= req_payload.weight_second;
      end
   end

   // Multiply each rotation word by its vector component; pick translation
   always_comb begin
      for (int b = 0; b < 2; b++) begin
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               prod_s2_in[b][c][r] =
                  tbvs_pkg::prod_type'(tbvs_pkg::elem_type'(
                     rd_row[b][(r*3 + c)*tbvs_pkg::ELEM_BITS +: tbvs_pkg::ELEM_BITS])) *
                  tbvs_pkg::prod_type'(vec_s1_ff[r]);
            end
            trans_s2_in[b][c] = point_s1_ff ?
               tbvs_pkg::elem_type'(rd_row[b][(tbvs_pkg::TRANS_ROW*3 + c)*tbvs_pkg::ELEM_BITS
                                              +: tbvs_pkg::ELEM_BITS]) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         prod_s2_ff  <= prod_s2_in;
         trans_s2_ff <= trans_s2_in;
         oob_s2_ff   <= oob_s1_ff;
         wt_s2_ff    <= wt_s1_ff;
         last_s2_ff  <= last_s1_ff;
      end
   end

   // Sum the three products and round once to Q16
   always_comb begin
      for (int b = 0; b < 2; b++) begin
         for (int c = 0; c < 3; c++) begin
            acc_s3[b][c] = tbvs_pkg::acc_type'(prod_s2_ff[b][c][0]) +
                           tbvs_pkg::acc_type'(prod_s2_ff[b][c][1]) +
                           tbvs_pkg::acc_type'(prod_s2_ff[b][c][2]) +
                           tbvs_pkg::ACC_ROUND;
            sum_s3_in[b][c] = acc_s3[b][c][tbvs_pkg::ACC_BITS-1:tbvs_pkg::VALUE_FRAC];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         sum_s3_ff   <= sum_s3_in;
         trans_s3_ff <= trans_s2_ff;
         oob_s3_ff   <= oob_s2_ff;
         wt_s3_ff    <= wt_s2_ff;
         last_s3_ff  <= last_s2_ff;
      end
   end

   // Add translation, saturate, zero an out-of-range bone
   always_comb begin
      for (int b = 0; b < 2; b++) begin
         for (int c = 0; c < 3; c++) begin
            tsum_s4[b][c] = tbvs_pkg::tran_type'(sum_s3_ff[b][c]) +
                            tbvs_pkg::tran_type'(trans_s3_ff[b][c]);
            priority if (oob_s3_ff[b]) begin
               comp_s4_in[b][c] = '0;
            end else if (tsum_s4[b][c] > tbvs_pkg::COMP_MAX) begin
               comp_s4_in[b][c] = tbvs_pkg::comp_type'(tbvs_pkg::COMP_MAX);
            end else if (tsum_s4[b][c] < tbvs_pkg::COMP_MIN) begin
               comp_s4_in[b][c] = tbvs_pkg::comp_type'(tbvs_pkg::COMP_MIN);
            end else begin
               comp_s4_in[b][c] = tsum_s4[b][c][tbvs_pkg::VALUE_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         comp_s4_ff <= comp_s4_in;
         wt_s4_ff   <= wt_s3_ff;
         last_s4_ff <= last_s3_ff;
      end
   end

   // Scale each bone component by its weight
   always_comb begin
      for (int b = 0; b < 2; b++) begin
         for (int c = 0; c < 3; c++) begin
            wprod_s5_in[b][c] = tbvs_pkg::wprod_type'(comp_s4_ff[b][c]) *
                                tbvs_pkg::wprod_type'($signed({1'b0, wt_s4_ff[b]}));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         wprod_s5_ff <= wprod_s5_in;
         last_s5_ff  <= last_s4_ff;
      end
   end

   // Blend both bones, round once to Q16, saturate to the output width
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc2_s6[c] = tbvs_pkg::acc2_type'(wprod_s5_ff[0][c]) +
                      tbvs_pkg::acc2_type'(wprod_s5_ff[1][c]) +
                      tbvs_pkg::ACC2_ROUND;
         blend_s6[c] = acc2_s6[c][tbvs_pkg::ACC2_BITS-1:tbvs_pkg::WEIGHT_FRAC];
         priority if (blend_s6[c] > tbvs_pkg::OUT_MAX) begin
            out_s6[c] = tbvs_pkg::out_type'(tbvs_pkg::OUT_MAX);
         end else if (blend_s6[c] < tbvs_pkg::OUT_MIN) begin
            out_s6[c] = tbvs_pkg::out_type'(tbvs_pkg::OUT_MIN);
         end else begin
            out_s6[c] = blend_s6[c][tbvs_pkg::OUT_BITS-1:0];
         end
      end
      rsp_in.out_x    = out_s6[0];
      rsp_in.out_y    = out_s6[1];
      rsp_in.out_z    = out_s6[2];
      rsp_in.out_last = last_s5_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = valid_ff[6];
   assign rsp_payload = rsp_ff;

   // An empty output stage leaves the whole pipeline free to take a transfer
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[6] |-> req_ready)
      else $error("req_ready low with output stage empty");

   // A load never enters the arithmetic pipeline
   a_load_no_entry: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_xform) |=> !valid_ff[1])
      else $error("load or unused code entered the pipeline");

   // Every transform transfer occupies stage 1 on the next cycle
   a_xform_entry: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_xform) |=> valid_ff[1])
      else $error("transform transfer lost at stage 1");

   // A held result stays put while the consumer stalls
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[6] && !rsp_ready) |=> (valid_ff[6] && $stable(rsp_ff)))
      else $error("output register changed under stall");

endmodule

// ===== rtl/core/tbvs_ram.sv =====
// ----------------------------------------------------------------------------
// tbvs_ram: generic lane-writable RAM with two registered read ports
// One write port with a per-lane enable, two read ports whose data registers
// update only when their read enable is high and hold otherwise.
// ----------------------------------------------------------------------------
module tbvs_ram #(
   parameter int LANE_BITS = 32,
   parameter int LANES     = 1,
   parameter int DEPTH     = 64,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int ROW       = LANE_BITS * LANES
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [LANES-1:0]     wr_lane_en,
   input  logic [ROW-1:0]       wr_data,
   input  logic                 rd_a_en,
   input  logic [ADDR_BITS-1:0] rd_a_addr,
   output logic [ROW-1:0]       rd_a_data,
   input  logic                 rd_b_en,
   input  logic [ADDR_BITS-1:0] rd_b_addr,
   output logic [ROW-1:0]       rd_b_data
);

   logic [ROW-1:0] mem [DEPTH];

   // Write the enabled lanes of one row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int l = 0; l < LANES; l++) begin
            if (wr_lane_en[l]) begin
               mem[wr_addr][l*LANE_BITS +: LANE_BITS] <= wr_data[l*LANE_BITS +: LANE_BITS];
            end
         end
      end
   end

   // Register both reads, hold when not enabled
   always_ff @(posedge clock) begin
      if (rd_a_en) begin
         rd_a_data <= mem[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_data <= mem[rd_b_addr];
      end
   end

endmodule
